@@ sv/vdbd_pkg.sv @@
// Package for the backward-difference divergence core: request and result
// payload types, field widths and configuration register indexes.
// No dependencies.
package vdbd_pkg;

  localparam int GRAD_BITS  = 16;
  localparam int DIV_BITS   = 19;
  localparam int SIZE_BITS  = 9;
  localparam int INDEX_BITS = 2;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic signed [GRAD_BITS-1:0] grad_z;
  } in_data_t;

  typedef struct packed {
    logic signed [DIV_BITS-1:0] divergence;
    logic                       volume_end;
  } out_data_t;

  typedef struct packed {
    logic has_x;
    logic has_y;
    logic has_z;
    logic vol_end;
  } pos_flags_t;

endpackage

@@ sv/vdbd_scan.sv @@
// Raster position tracker and size registers for the divergence core.
// Produces buffer addresses and neighbour flags for the voxel at the input.
// Depends on vdbd_pkg.
module vdbd_scan
  import vdbd_pkg::*;
#(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 256,
  localparam int XW = $clog2(MAX_X),
  localparam int YW = $clog2(MAX_Y),
  localparam int ZW = $clog2(MAX_Z),
  localparam int PW = $clog2(MAX_X * MAX_Y)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]  cfg_data,
  input  logic                  step,
  output logic [XW-1:0]         row_addr,
  output logic [PW-1:0]         plane_addr,
  output pos_flags_t            flags
);

  localparam int XE = ((XW > SIZE_BITS) ? XW : SIZE_BITS) + 1;
  localparam int YE = ((YW > SIZE_BITS) ? YW : SIZE_BITS) + 1;
  localparam int ZE = ((ZW > SIZE_BITS) ? ZW : SIZE_BITS) + 1;

  logic [SIZE_BITS-1:0] size_x;
  logic [SIZE_BITS-1:0] size_y;
  logic [SIZE_BITS-1:0] size_z;
  logic [XW-1:0]        pos_x;
  logic [YW-1:0]        pos_y;
  logic [ZW-1:0]        pos_z;
  logic [XE-1:0]        eff_x;
  logic [YE-1:0]        eff_y;
  logic [ZE-1:0]        eff_z;
  logic                 end_x;
  logic                 end_y;
  logic                 end_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_BITS'(256);
      size_y <= SIZE_BITS'(256);
      size_z <= SIZE_BITS'(256);
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one; a size beyond the build maximum is clipped.
  always_comb begin
    if (size_x == '0) eff_x = XE'(1);
    else if (32'(size_x) > MAX_X) eff_x = XE'(MAX_X);
    else eff_x = XE'(size_x);
    if (size_y == '0) eff_y = YE'(1);
    else if (32'(size_y) > MAX_Y) eff_y = YE'(MAX_Y);
    else eff_y = YE'(size_y);
    if (size_z == '0) eff_z = ZE'(1);
    else if (32'(size_z) > MAX_Z) eff_z = ZE'(MAX_Z);
    else eff_z = ZE'(size_z);
  end

  assign end_x = (XE'(pos_x) + XE'(1)) >= eff_x;
  assign end_y = (YE'(pos_y) + YE'(1)) >= eff_y;
  assign end_z = (ZE'(pos_z) + ZE'(1)) >= eff_z;

  assign row_addr   = pos_x;
  assign plane_addr = PW'(PW'(pos_y) * PW'(MAX_X)) + PW'(pos_x);

  assign flags.has_x   = pos_x != '0;
  assign flags.has_y   = pos_y != '0;
  assign flags.has_z   = pos_z != '0;
  assign flags.vol_end = end_x & end_y & end_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (step) begin
      if (!end_x) begin
        pos_x <= pos_x + XW'(1);
      end else begin
        pos_x <= '0;
        if (!end_y) begin
          pos_y <= pos_y + YW'(1);
        end else begin
          pos_y <= '0;
          pos_z <= end_z ? '0 : pos_z + ZW'(1);
        end
      end
    end
  end

endmodule

@@ sv/vdbd_buf.sv @@
// Row buffer of y gradients and plane buffer of z gradients.
// Each entry is read and overwritten in the same cycle; read data is registered.
// Depends on vdbd_pkg.
module vdbd_buf
  import vdbd_pkg::*;
#(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  localparam int XW = $clog2(MAX_X),
  localparam int PW = $clog2(MAX_X * MAX_Y)
) (
  input  logic                        clk,
  input  logic                        step,
  input  logic [XW-1:0]               row_addr,
  input  logic [PW-1:0]               plane_addr,
  input  logic signed [GRAD_BITS-1:0] grad_y,
  input  logic signed [GRAD_BITS-1:0] grad_z,
  output logic signed [GRAD_BITS-1:0] row_rd,
  output logic signed [GRAD_BITS-1:0] plane_rd
);

  logic [GRAD_BITS-1:0] row_mem   [MAX_X];
  logic [GRAD_BITS-1:0] plane_mem [MAX_X * MAX_Y];

  // The read returns the value held before this cycle's write.
  always_ff @(posedge clk) begin
    if (step) begin
      row_rd             <= row_mem[row_addr];
      row_mem[row_addr]  <= grad_y;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      plane_rd               <= plane_mem[plane_addr];
      plane_mem[plane_addr]  <= grad_z;
    end
  end

endmodule

@@ sv/volume_divergence_backward_diff_core.sv @@
// Backward-difference negative divergence over a raster-ordered voxel stream.
// Top level: request pipeline, x history and result register. Uses vdbd_pkg,
// vdbd_scan and vdbd_buf.
//
// Each request carries one voxel's gradient, x fastest, then y, then z, and
// yields one result: (previous gx - gx) + (gy one row back - gy) +
// (gz one plane back - gz), with neighbours outside the volume taken as zero,
// and a flag on the last voxel of the volume. The core takes one request per
// cycle while the output is not stalled. The request is registered with the
// registered read of the row and plane buffers, read and rewritten at the same
// entry as the request is taken, and the result is then registered. The row
// buffer holds MAX_X words and the plane buffer MAX_X*MAX_Y words. The user
// writes size registers only while no request is in flight; the core does not
// enforce this. The scan position returns to the origin after each volume ends.
module volume_divergence_backward_diff_core
  import vdbd_pkg::*;
#(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_data_t             out_data
);

  localparam int XW = $clog2(MAX_X);
  localparam int PW = $clog2(MAX_X * MAX_Y);

  logic                        accept;
  logic                        s1_adv;
  logic [XW-1:0]               row_addr;
  logic [PW-1:0]               plane_addr;
  pos_flags_t                  flags;
  logic signed [GRAD_BITS-1:0] prev_gx;
  logic signed [GRAD_BITS:0]   term_x;
  logic signed [GRAD_BITS-1:0] row_rd;
  logic signed [GRAD_BITS-1:0] plane_rd;
  logic signed [GRAD_BITS-1:0] y_prev;
  logic signed [GRAD_BITS-1:0] z_prev;
  logic signed [DIV_BITS-1:0]  div_next;

  logic                        s1_valid;
  logic signed [GRAD_BITS:0]   s1_term_x;
  logic signed [GRAD_BITS-1:0] s1_gy;
  logic signed [GRAD_BITS-1:0] s1_gz;
  logic                        s1_has_y;
  logic                        s1_has_z;
  logic                        s1_end;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign accept    = in_valid && in_ready;

  vdbd_scan #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (accept),
    .row_addr   (row_addr),
    .plane_addr (plane_addr),
    .flags      (flags)
  );

  vdbd_buf #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y)
  ) u_buf (
    .clk        (clk),
    .step       (accept),
    .row_addr   (row_addr),
    .plane_addr (plane_addr),
    .grad_y     (in_data.grad_y),
    .grad_z     (in_data.grad_z),
    .row_rd     (row_rd),
    .plane_rd   (plane_rd)
  );

  assign term_x = (flags.has_x ? (GRAD_BITS+1)'(prev_gx) : '0)
                - (GRAD_BITS+1)'(in_data.grad_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_gx <= '0;
    end else if (accept) begin
      prev_gx <= in_data.grad_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_term_x <= term_x;
      s1_gy     <= in_data.grad_y;
      s1_gz     <= in_data.grad_z;
      s1_has_y  <= flags.has_y;
      s1_has_z  <= flags.has_z;
      s1_end    <= flags.vol_end;
    end
  end

  assign y_prev   = s1_has_y ? row_rd : '0;
  assign z_prev   = s1_has_z ? plane_rd : '0;
  assign div_next = DIV_BITS'(s1_term_x) + DIV_BITS'(y_prev) - DIV_BITS'(s1_gy)
                  + DIV_BITS'(z_prev) - DIV_BITS'(s1_gz);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_data.divergence <= div_next;
      out_data.volume_end <= s1_end;
    end
  end

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request did not reach the buffer read stage");

  a_s1_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_term_x) && $stable(s1_gy)
                               && $stable(s1_gz) && $stable(row_rd)
                               && $stable(plane_rd)))
    else $error("stalled request lost its operands or buffer read data");

  a_s1_moves_out : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> out_valid)
    else $error("request left the read stage without producing a result");

endmodule

@@ tb/sv/tb_volume_divergence_backward_diff_core.sv @@
// Self-checking testbench for volume_divergence_backward_diff_core: drives voxel
// gradient requests and size register writes, predicts each divergence and flag.
// Depends on vdbd_pkg and the core RTL.
module tb_volume_divergence_backward_diff_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vdbd_pkg::*;

  localparam int MAX_X = 256;
  localparam int MAX_Y = 256;
  localparam int MAX_Z = 256;
  localparam logic signed [GRAD_BITS-1:0] GRAD_MAX = 16'sh7fff;
  localparam logic signed [GRAD_BITS-1:0] GRAD_MIN = 16'sh8000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  class divergence_board;
    logic [SIZE_BITS-1:0] size_reg [3];
    int prev_gx;
    int row_gy [MAX_X];
    int plane_gz [MAX_X*MAX_Y];
    int pos_x, pos_y, pos_z;
    bit last_end;
    int fails;
    out_data_t pending_divs [$];

    function new();
      foreach (size_reg[i]) size_reg[i] = 9'd256;
      prev_gx = 0;
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      last_end = 1'b0;
      fails = 0;
    endfunction

    function int span(reg_index_t idx);
      int limit = (idx == REG_SIZE_X) ? MAX_X : (idx == REG_SIZE_Y) ? MAX_Y : MAX_Z;
      int value = int'(size_reg[idx]);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
    endfunction

    function bit at_origin();
      return pos_x == 0 && pos_y == 0 && pos_z == 0;
    endfunction

    function void predict_voxel(in_data_t v);
      int gx, gy, gz, sx, sy, sz, pidx, div;
      bit ex, ey, ez;
      out_data_t e;
      gx = int'(v.grad_x);
      gy = int'(v.grad_y);
      gz = int'(v.grad_z);
      sx = span(REG_SIZE_X);
      sy = span(REG_SIZE_Y);
      sz = span(REG_SIZE_Z);
      pidx = pos_y * MAX_X + pos_x;
      div = (pos_x > 0 ? prev_gx : 0) - gx
          + (pos_y > 0 ? row_gy[pos_x] : 0) - gy
          + (pos_z > 0 ? plane_gz[pidx] : 0) - gz;
      prev_gx = gx;
      row_gy[pos_x] = gy;
      plane_gz[pidx] = gz;
      ex = pos_x + 1 >= sx;
      ey = pos_y + 1 >= sy;
      ez = pos_z + 1 >= sz;
      e.divergence = div[DIV_BITS-1:0];
      e.volume_end = ex && ey && ez;
      last_end = e.volume_end;
      pending_divs.push_back(e);
      if (!ex) begin
        pos_x++;
      end else begin
        pos_x = 0;
        if (!ey) begin
          pos_y++;
        end else begin
          pos_y = 0;
          pos_z = ez ? 0 : pos_z + 1;
        end
      end
    endfunction

    function void check_divergence(out_data_t got);
      out_data_t want;
      if (pending_divs.size() == 0) begin
        fails++;
        $display("%0t: result with nothing expected, divergence %0d volume_end %0b",
                 $time, $signed(got.divergence), got.volume_end);
        return;
      end
      want = pending_divs.pop_front();
      if (got.divergence !== want.divergence) begin
        fails++;
        $display("%0t: divergence expected %0d actual %0d",
                 $time, $signed(want.divergence), $signed(got.divergence));
      end
      if (got.volume_end !== want.volume_end) begin
        fails++;
        $display("%0t: volume_end expected %0b actual %0b",
                 $time, want.volume_end, got.volume_end);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [INDEX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0]  cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_data_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_data_t             out_data;

  divergence_board board = new();
  int sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  volume_divergence_backward_diff_core #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= $urandom_range(0, 3) != 0;
      default: out_ready <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_divergence(out_data);
    end
  end

  function automatic logic signed [GRAD_BITS-1:0] rand_grad();
    case ($urandom_range(0, 9))
      0: return GRAD_MAX;
      1: return GRAD_MIN;
      2: return '0;
      default: return GRAD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_voxel(input logic signed [GRAD_BITS-1:0] gx, gy, gz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data <= '{grad_x: gx, grad_y: gy, grad_z: gz};
    do @(posedge clk); while (!in_ready);
    board.predict_voxel(in_data);
    burst_left--;
    sent++;
  endtask

  task automatic send_random_voxel();
    send_voxel(rand_grad(), rand_grad(), rand_grad());
  endtask

  // Size writes are only made once every request has produced its result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_divs.size() != 0);
  endtask

  task automatic write_size(input reg_index_t idx, input logic [SIZE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.size_reg[idx] = value;
  endtask

  task automatic configure(input logic [SIZE_BITS-1:0] sx, sy, sz);
    write_size(REG_SIZE_X, sx);
    write_size(REG_SIZE_Y, sy);
    write_size(REG_SIZE_Z, sz);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SIZE_BITS-1:0] next_size [3];
    bit big_done;
    bit partial;
    int dim;
    int count;
    big_done = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_SIZE_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The last voxel of a 2x2x2 volume sees the largest and then the smallest sum.
    configure(9'd2, 9'd2, 9'd2);
    repeat (7) send_voxel(GRAD_MAX, GRAD_MAX, GRAD_MAX);
    send_voxel(GRAD_MIN, GRAD_MIN, GRAD_MIN);
    repeat (7) send_voxel(GRAD_MIN, GRAD_MIN, GRAD_MIN);
    send_voxel(GRAD_MAX, GRAD_MAX, GRAD_MAX);
    wait_idle();
    configure(9'd0, 9'd0, 9'd0);
    send_voxel(16'sd0, 16'sd0, 16'sd0);
    send_voxel(-16'sd1, -16'sd1, -16'sd1);
    wait_idle();
    configure(9'd511, 9'd256, 9'd300);
    repeat (5) send_random_voxel();
    wait_idle();
    // Shrinking the row below the current position ends the volume on the next voxel.
    configure(9'd3, 9'd1, 9'd1);
    send_random_voxel();
    wait_idle();

    // Sizes only shrink while a volume is under way, so no unwritten entry is read.
    while (sent < 450) begin
      if (board.at_origin()) begin
        if (!big_done || $urandom_range(0, 11) == 0) begin
          dim = $urandom_range(0, 2);
          foreach (next_size[i]) next_size[i] = SIZE_BITS'($urandom_range(0, 1));
          next_size[dim] = $urandom_range(0, 1) ? 9'd256 : SIZE_BITS'($urandom_range(257, 511));
          partial = big_done;
          big_done = 1'b1;
        end else begin
          foreach (next_size[i]) next_size[i] = SIZE_BITS'($urandom_range(0, 6));
          partial = $urandom_range(0, 3) == 0;
        end
      end else begin
        foreach (next_size[i]) begin
          next_size[i] = SIZE_BITS'($urandom_range(0, board.span(reg_index_t'(i))));
        end
        partial = $urandom_range(0, 3) == 0;
      end
      configure(next_size[0], next_size[1], next_size[2]);
      count = partial ? $urandom_range(1, 12) : 1 << 30;
      do begin
        send_random_voxel();
        count--;
      end while (count > 0 && !board.last_end);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (board.fails == 0) begin
      $display("volume_divergence_backward_diff_core: match");
    end else begin
      $display("volume_divergence_backward_diff_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("volume_divergence_backward_diff_core: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/vdbd_pkg.sv
sv/vdbd_scan.sv
sv/vdbd_buf.sv
sv/volume_divergence_backward_diff_core.sv
tb/sv/tb_volume_divergence_backward_diff_core.sv
